// File: hw/rtl/png_scanline_unfilter_macros.svh
// assertion macros used by the port checker file
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// concurrent assertion sampled on clk, disabled while rst is high
`define PUS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion sampled on clk, also checked during reset
`define PUS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pus_pkg.sv
// shared types and constants of the png scanline unfilter
`default_nettype none

package pus_pkg;

  // filter type codes of a row
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ALPHA  = 2'd2
  } cfg_reg_t;

  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 16;
  // wide enough for 4095 * 4 and for row byte limits up to 262143
  localparam int CALC_W   = 18;

  // one sample on its way from the column counter to reconstruction
  typedef struct packed {
    logic [7:0] sample;
    logic [1:0] ch;
    filter_t    filt;
    logic       bad;
    logic       row0;
    logic       row_end;
    logic       image_end;
  } pus_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/pus_line_store.sv
// previous-row line store with registered read, write forwarding and fill tracking
`default_nettype none

module pus_line_store #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(MAX_ROW_BYTES)-1:0] rd_addr,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(MAX_ROW_BYTES)-1:0] wr_addr,
  input  wire logic [7:0]                       wr_data,
  output logic      [7:0]                       rd_data,
  output logic                                  rd_hit
);

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);

  logic [7:0]       mem [MAX_ROW_BYTES];
  // entries below fill have been written since reset; rows write from column zero up
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] rd_ext;
  logic [LEN_W-1:0] wr_ext;

  assign rd_ext = LEN_W'(rd_addr);
  assign wr_ext = LEN_W'(wr_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en && (wr_ext >= fill)) begin
        fill <= wr_ext + LEN_W'(1);
      end
      if (rd_en) begin
        rd_hit <= (rd_ext < fill) || (wr_en && (rd_ext <= wr_ext));
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pus_ctrl.sv
// row and column sequencing: filter bytes, column position, row and image ends
`default_nettype none

module pus_ctrl #(
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_ROW_BYTES = 8192
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [pus_pkg::WIDTH_W-1:0]       image_width,
  input  wire logic [pus_pkg::HEIGHT_W-1:0]      image_height,
  input  wire logic                              has_alpha,
  input  wire logic                              accept,
  input  wire logic [7:0]                        stream_byte,
  output logic                                   sample_load,
  output logic                                   clear_nbrs,
  output logic      [$clog2(MAX_ROW_BYTES)-1:0]  col,
  output pus_pkg::pus_item_t                     item
);

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int CW     = pus_pkg::CALC_W;
  localparam int HW     = pus_pkg::HEIGHT_W;
  // channel of the last byte when the row is cut at the byte limit
  localparam logic [1:0] CH3_SAT = 2'((MAX_ROW_BYTES - 1) % 3);
  localparam logic [1:0] CH4_SAT = 2'((MAX_ROW_BYTES - 1) % 4);

  logic                   awaiting;
  logic [LEN_W-1:0]       column_count;
  logic [1:0]             mod3;
  logic [HW-1:0]          row_count;
  pus_pkg::filter_t       row_filter;
  logic                   filter_invalid;

  logic [CW-1:0]          w_ext;
  logic [CW-1:0]          w_sat;
  logic [CW-1:0]          n_raw;
  logic [CW-1:0]          len_c;
  logic                   sat;
  logic [LEN_W-1:0]       len;
  logic                   clamp;
  logic [LEN_W-1:0]       col_full;
  logic [1:0]             ch;
  logic                   rend;
  logic                   iend;
  logic [HW-1:0]          height;

  always_comb begin
    w_ext = CW'(image_width);
    if (image_width == '0) begin
      w_sat = CW'(1);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_sat = CW'(MAX_WIDTH);
    end else begin
      w_sat = w_ext;
    end
    n_raw = has_alpha ? (w_sat << 2) : (w_sat + (w_sat << 1));
    sat   = n_raw > CW'(MAX_ROW_BYTES);
    len_c = sat ? CW'(MAX_ROW_BYTES) : n_raw;
    len   = len_c[LEN_W-1:0];

    // a shrink of the row length mid-row pins the column to the last one
    clamp    = column_count >= len;
    col_full = clamp ? (len - LEN_W'(1)) : column_count;

    if (has_alpha) begin
      ch = clamp ? (sat ? CH4_SAT : 2'd3) : column_count[1:0];
    end else begin
      ch = clamp ? (sat ? CH3_SAT : 2'd2) : mod3;
    end

    height = (image_height == '0) ? HW'(1) : image_height;
    rend   = ({1'b0, col_full} + (LEN_W + 1)'(1)) >= {1'b0, len};
    iend   = rend && (({1'b0, row_count} + (HW + 1)'(1)) >= {1'b0, height});
  end

  assign col         = col_full[ADDR_W-1:0];
  assign sample_load = accept && !awaiting;
  assign clear_nbrs  = accept && awaiting;

  always_comb begin
    item.sample    = stream_byte;
    item.ch        = ch;
    item.filt      = row_filter;
    item.bad       = filter_invalid;
    item.row0      = (row_count == '0);
    item.row_end   = rend;
    item.image_end = iend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting       <= 1'b1;
      column_count   <= '0;
      mod3           <= 2'd0;
      row_count      <= '0;
      row_filter     <= pus_pkg::FILT_NONE;
      filter_invalid <= 1'b0;
    end else if (accept) begin
      if (awaiting) begin
        // unknown filter types run as none and mark the row
        if (stream_byte > 8'd4) begin
          row_filter     <= pus_pkg::FILT_NONE;
          filter_invalid <= 1'b1;
        end else begin
          row_filter     <= pus_pkg::filter_t'(stream_byte[2:0]);
          filter_invalid <= 1'b0;
        end
        column_count <= '0;
        mod3         <= 2'd0;
        awaiting     <= 1'b0;
      end else if (rend) begin
        awaiting     <= 1'b1;
        column_count <= '0;
        mod3         <= 2'd0;
        row_count    <= iend ? '0 : (row_count + HW'(1));
      end else begin
        column_count <= col_full + LEN_W'(1);
        mod3         <= (mod3 == 2'd2) ? 2'd0 : (mod3 + 2'd1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pus_recon.sv
// reconstruction stage: neighbor bytes, predictor, write-back and output register
`default_nettype none

module pus_recon #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             load,
  input  wire logic                             clear_nbrs,
  input  wire pus_pkg::pus_item_t               item,
  input  wire logic [$clog2(MAX_ROW_BYTES)-1:0] col,
  input  wire logic [7:0]                       rd_data,
  input  wire logic                             rd_hit,
  output logic                                  stage_free,
  output logic                                  wr_en,
  output logic      [$clog2(MAX_ROW_BYTES)-1:0] wr_addr,
  output logic      [7:0]                       wr_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [7:0]                       out_byte,
  output logic                                  out_row_end,
  output logic                                  out_image_end,
  output logic                                  out_bad
);

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic                 s1_valid;
  pus_pkg::pus_item_t   s1;
  logic [ADDR_W-1:0]    s1_col;
  logic                 s1_adv;

  logic [7:0]           left_bytes [4];
  logic [7:0]           upper_left_bytes [4];

  logic [7:0]           a;
  logic [7:0]           b;
  logic [7:0]           c;
  logic [8:0]           ab_sum;
  logic [8:0]           pa;
  logic [8:0]           pb;
  logic [8:0]           pc;
  logic [7:0]           pred;
  logic [7:0]           r;

  function automatic logic [8:0] absdiff(input logic [8:0] p, input logic [8:0] q);
    absdiff = (p > q) ? (p - q) : (q - p);
  endfunction

  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign stage_free = !s1_valid || s1_adv;

  always_comb begin
    a      = left_bytes[s1.ch];
    b      = (s1.row0 || !rd_hit) ? 8'd0 : rd_data;
    c      = s1.row0 ? 8'd0 : upper_left_bytes[s1.ch];
    ab_sum = {1'b0, a} + {1'b0, b};
    pa     = absdiff({1'b0, b}, {1'b0, c});
    pb     = absdiff({1'b0, a}, {1'b0, c});
    pc     = absdiff(ab_sum, {c, 1'b0});
    unique case (s1.filt)
      pus_pkg::FILT_SUB:   pred = a;
      pus_pkg::FILT_UP:    pred = b;
      pus_pkg::FILT_AVG:   pred = ab_sum[8:1];
      pus_pkg::FILT_PAETH: begin
        if ((pa <= pb) && (pa <= pc)) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:             pred = 8'd0;
    endcase
    r = s1.sample + pred;
  end

  assign wr_en   = s1_adv;
  assign wr_addr = s1_col;
  assign wr_data = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1     <= item;
      s1_col <= col;
    end
  end

  // a filter byte is taken only when the stage is free; its clear wins over the last update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        left_bytes[i]       <= 8'd0;
        upper_left_bytes[i] <= 8'd0;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (clear_nbrs) begin
          left_bytes[i]       <= 8'd0;
          upper_left_bytes[i] <= 8'd0;
        end else if (s1_adv && (s1.ch == 2'(i))) begin
          left_bytes[i]       <= r;
          upper_left_bytes[i] <= b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte      <= r;
      out_row_end   <= s1.row_end;
      out_image_end <= s1.image_end;
      out_bad       <= s1.bad;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/png_scanline_unfilter.sv
// top level of the png scanline unfilter
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  s_tdata: filter type byte or filtered sample
//  m_*      out        m_tvalid/m_tready  m_tdata: sample, m_tlast: row end,
//                                         m_tuser: image end, bad filter
//  cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// one byte per cycle sustained while m_tready stays high; a sample is registered by the
// line store read and the reconstruction register together, then by the output register.
// filter type bytes give no output transfer.
// reset is synchronous; the line store needs no clearing pass,
// unwritten entries read as zero through a fill count.
// a stalled m side holds one result in the output register and one in the
// reconstruction stage before s_tready drops.
`default_nettype none

module png_scanline_unfilter #(
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_ROW_BYTES = 8192
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // [7:0] stream_byte
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic      [7:0]                m_tdata,   // [7:0] pixel_byte
  output logic                           m_tlast,
  output logic      [1:0]                m_tuser,   // [0] image_end, [1] bad_filter
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [pus_pkg::CFG_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic [pus_pkg::WIDTH_W-1:0]  image_width;
  logic [pus_pkg::HEIGHT_W-1:0] image_height;
  logic                         has_alpha;

  logic                         accept;
  logic                         sample_load;
  logic                         clear_nbrs;
  logic [ADDR_W-1:0]            rd_addr;
  pus_pkg::pus_item_t           item;
  logic [7:0]                   rd_data;
  logic                         rd_hit;
  logic                         stage_free;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [7:0]                   wr_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = stage_free;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pus_pkg::WIDTH_W'(1);
      image_height <= pus_pkg::HEIGHT_W'(1);
      has_alpha    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pus_pkg::cfg_reg_t'(cfg_index))
        pus_pkg::REG_WIDTH:  image_width  <= cfg_data[pus_pkg::WIDTH_W-1:0];
        pus_pkg::REG_HEIGHT: image_height <= cfg_data[pus_pkg::HEIGHT_W-1:0];
        pus_pkg::REG_ALPHA:  has_alpha    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pus_ctrl #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .has_alpha    (has_alpha),
    .accept       (accept),
    .stream_byte  (s_tdata),
    .sample_load  (sample_load),
    .clear_nbrs   (clear_nbrs),
    .col          (rd_addr),
    .item         (item)
  );

  pus_line_store #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (sample_load),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_hit  (rd_hit)
  );

  pus_recon #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_recon (
    .clk           (clk),
    .rst           (rst),
    .load          (sample_load),
    .clear_nbrs    (clear_nbrs),
    .item          (item),
    .col           (rd_addr),
    .rd_data       (rd_data),
    .rd_hit        (rd_hit),
    .stage_free    (stage_free),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_byte      (m_tdata),
    .out_row_end   (m_tlast),
    .out_image_end (m_tuser[0]),
    .out_bad       (m_tuser[1])
  );

endmodule

`default_nettype wire

// File: hw/rtl/pus_port_checker.sv
// port-level checks of the png scanline unfilter and their bind
`default_nettype none

`include "png_scanline_unfilter_macros.svh"

module pus_port_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic [7:0]                s_tdata,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [7:0]                m_tdata,
  input wire logic                      m_tlast,
  input wire logic [1:0]                m_tuser,
  input wire logic                      cfg_valid,
  input wire logic                      cfg_ready,
  input wire logic [1:0]                cfg_index,
  input wire logic [pus_pkg::CFG_W-1:0] cfg_data
);

  // the image ends only on the last byte of a row
  `PUS_ASSERT(a_image_end_on_row_end, (m_tvalid && m_tuser[0]) |-> m_tlast, "image end without row end")

  // a stalled result keeps its payload
  `PUS_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)), "stalled output changed")

  // nothing is offered in the cycle after reset
  `PUS_ASSERT_ALWAYS(a_quiet_after_reset, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule

bind png_scanline_unfilter pus_port_checker u_port_checker (.*);

`default_nettype wire
